[rtl/hocc_pkg.sv]
// ----------------------------------------------------------------------------
// hocc_pkg
// Item types and controller/datapath handshake structs for the half-open
// connection counter.
// ----------------------------------------------------------------------------
`default_nettype none

package hocc_pkg;

  localparam int IP_W     = 32;
  localparam int RIDX_W   = 6;
  localparam int OIDX_W   = 6;
  localparam int OCNT_W   = 16;
  localparam int OUSED_W  = 7;

  localparam logic OP_PACKET = 1'b0;
  localparam logic OP_READ   = 1'b1;

  typedef struct packed {
    logic              opcode;
    logic              is_tcp;
    logic              flag_syn;
    logic              flag_ack;
    logic [IP_W-1:0]   src_ip;
    logic [IP_W-1:0]   dst_ip;
    logic [RIDX_W-1:0] read_index;
  } req_t;

  typedef struct packed {
    logic [OIDX_W-1:0]        entry_index;
    logic [IP_W-1:0]          entry_ip;
    logic signed [OCNT_W-1:0] entry_count;
    logic                     hit;
    logic                     inserted;
    logic                     table_full;
    logic                     half_open;
    logic [OUSED_W-1:0]       entries_used;
  } rsp_t;

  // controller -> datapath
  typedef struct packed {
    logic start;    // capture incoming item, clear scan state
    logic scan_en;  // step the lookup scan
    logic rd_sel;   // memory read address from read_index
    logic commit;   // apply update, form result
    logic xfer;     // move result to output register
  } ctl_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic in_read;  // incoming item is a table read
    logic in_scan;  // incoming item is a TCP SYN that needs a lookup
    logic match;    // scan found the key
    logic miss;     // scan exhausted the occupied entries
    logic out_free; // output register can take a result
  } ctl_status_t;

endpackage

`default_nettype wire

[rtl/hocc_ctrl.sv]
// ----------------------------------------------------------------------------
// hocc_ctrl
// Sequencer: accept, lookup scan or read, commit, hand off result.
// ----------------------------------------------------------------------------
`default_nettype none

module hocc_ctrl
  import hocc_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        req_valid,
  output logic             req_ready,
  input  wire ctl_status_t st,
  output ctl_cmd_t         cmd
);

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_SCAN   = 5'b00010,
    S_RDADR  = 5'b00100,
    S_COMMIT = 5'b01000,
    S_EMIT   = 5'b10000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    req_ready  = 1'b0;
    unique case (state)
      S_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          cmd.start = 1'b1;
          priority if (st.in_read) state_next = S_RDADR;
          else if (st.in_scan)     state_next = S_SCAN;
          else                     state_next = S_COMMIT;
        end
      end
      S_SCAN: begin
        cmd.scan_en = 1'b1;
        if (st.match || st.miss) state_next = S_COMMIT;
      end
      S_RDADR: begin
        cmd.rd_sel = 1'b1;
        state_next = S_COMMIT;
      end
      S_COMMIT: begin
        cmd.commit = 1'b1;
        state_next = S_EMIT;
      end
      S_EMIT: begin
        if (st.out_free) begin
          cmd.xfer   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

`default_nettype wire

[rtl/hocc_dp.sv]
// ----------------------------------------------------------------------------
// hocc_dp
// Address/count tables, lookup scan pipeline, update logic and result
// registers.
// ----------------------------------------------------------------------------
`default_nettype none

module hocc_dp
  import hocc_pkg::*;
#(
  parameter int ENTRIES    = 64,
  parameter int COUNT_BITS = 16
) (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire req_t     req,
  input  wire ctl_cmd_t cmd,
  output ctl_status_t   st,
  output logic          rsp_valid,
  input  wire logic     rsp_ready,
  output rsp_t          rsp
);

  localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CNT_W = $clog2(ENTRIES + 1);
  localparam int CMP_W = (CNT_W > RIDX_W) ? CNT_W : RIDX_W;

  localparam logic signed [COUNT_BITS-1:0] CMAX = {1'b0, {(COUNT_BITS-1){1'b1}}};
  localparam logic signed [COUNT_BITS-1:0] CMIN = {1'b1, {(COUNT_BITS-1){1'b0}}};
  localparam logic signed [COUNT_BITS-1:0] CONE = COUNT_BITS'(1);

  logic [IP_W-1:0]              addr_mem [ENTRIES];
  logic signed [COUNT_BITS-1:0] cnt_mem  [ENTRIES];

  req_t                         item;
  logic [CNT_W-1:0]             used;
  logic [CNT_W-1:0]             scan_idx;
  logic [CNT_W-1:0]             pipe_idx;
  logic                         pipe_valid;
  logic [IP_W-1:0]              mem_a_q;
  logic signed [COUNT_BITS-1:0] mem_c_q;
  logic                         found;
  logic [IDX_W-1:0]             hit_idx;
  logic signed [COUNT_BITS-1:0] hit_cnt;
  rsp_t                         pend;

  logic                         syn_only;
  logic [IP_W-1:0]              key;
  logic [IDX_W-1:0]             rd_addr;
  logic                         issue;
  logic                         rd_occupied;
  logic                         has_room;
  logic signed [COUNT_BITS-1:0] new_cnt;
  logic                         wr_cnt;
  logic                         wr_ins;
  logic [IDX_W-1:0]             wr_addr;
  logic [CNT_W-1:0]             used_next;
  rsp_t                         pend_next;

  assign syn_only    = !item.flag_ack;
  assign key         = syn_only ? item.src_ip : item.dst_ip;
  assign issue       = cmd.scan_en && (scan_idx < used);
  assign rd_addr     = cmd.rd_sel ? IDX_W'(item.read_index) : scan_idx[IDX_W-1:0];
  assign rd_occupied = CMP_W'(item.read_index) < CMP_W'(used);
  assign has_room    = used < CNT_W'(ENTRIES);

  assign st.in_read  = (req.opcode == OP_READ);
  assign st.in_scan  = req.is_tcp && req.flag_syn;
  assign st.match    = pipe_valid && (mem_a_q == key);
  assign st.miss     = !st.match &&
                       ((used == '0) || (pipe_valid && (pipe_idx == CNT_W'(used - 1'b1))));
  assign st.out_free = !rsp_valid || rsp_ready;

  // saturating step on the matched entry
  always_comb begin
    if (syn_only) begin
      new_cnt = (hit_cnt == CMAX) ? hit_cnt : hit_cnt + CONE;
    end else begin
      new_cnt = (hit_cnt == CMIN) ? hit_cnt : hit_cnt - CONE;
    end
  end

  always_comb begin
    pend_next = '0;
    wr_cnt    = 1'b0;
    wr_ins    = 1'b0;
    wr_addr   = hit_idx;
    used_next = used;
    priority if (item.opcode == OP_READ) begin
      pend_next.entry_index = OIDX_W'(item.read_index);
      if (rd_occupied) begin
        pend_next.entry_ip    = mem_a_q;
        pend_next.entry_count = OCNT_W'(mem_c_q);
        pend_next.hit         = 1'b1;
        pend_next.half_open   = (mem_c_q > 0);
      end
    end else if (!(item.is_tcp && item.flag_syn)) begin
      pend_next = '0;
    end else if (found) begin
      wr_cnt                = 1'b1;
      pend_next.entry_index = OIDX_W'(hit_idx);
      pend_next.entry_ip    = key;
      pend_next.entry_count = OCNT_W'(new_cnt);
      pend_next.hit         = 1'b1;
      pend_next.half_open   = (new_cnt > 0);
    end else if (syn_only && has_room) begin
      wr_cnt                = 1'b1;
      wr_ins                = 1'b1;
      wr_addr               = used[IDX_W-1:0];
      used_next             = used + 1'b1;
      pend_next.entry_index = OIDX_W'(used);
      pend_next.entry_ip    = item.src_ip;
      pend_next.entry_count = OCNT_W'(CONE);
      pend_next.inserted    = 1'b1;
      pend_next.half_open   = 1'b1;
    end else if (syn_only) begin
      pend_next.entry_ip   = item.src_ip;
      pend_next.table_full = 1'b1;
    end else begin
      pend_next.entry_ip = item.dst_ip;
    end
    pend_next.entries_used = OUSED_W'(used_next);
  end

  // tables: one write port, one registered read port each
  always_ff @(posedge clk) begin
    if (cmd.commit && wr_ins) begin
      addr_mem[wr_addr] <= item.src_ip;
    end
    mem_a_q <= addr_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (cmd.commit && wr_cnt) begin
      cnt_mem[wr_addr] <= wr_ins ? CONE : new_cnt;
    end
    mem_c_q <= cnt_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      used       <= '0;
      pipe_valid <= 1'b0;
      rsp_valid  <= 1'b0;
    end else begin
      if (cmd.start) begin
        pipe_valid <= 1'b0;
      end else begin
        pipe_valid <= issue;
      end
      if (cmd.commit) begin
        used <= used_next;
      end
      if (cmd.xfer) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      item     <= req;
      scan_idx <= '0;
      found    <= 1'b0;
    end else if (issue) begin
      scan_idx <= scan_idx + 1'b1;
    end
    if (issue) begin
      pipe_idx <= scan_idx;
    end
    // hold the matched entry; later reads overwrite the memory outputs
    if (cmd.scan_en && st.match) begin
      found   <= 1'b1;
      hit_idx <= pipe_idx[IDX_W-1:0];
      hit_cnt <= mem_c_q;
    end
    if (cmd.commit) begin
      pend <= pend_next;
    end
    if (cmd.xfer) begin
      rsp <= pend;
    end
  end

endmodule

`default_nettype wire

[rtl/half_open_connection_counter.sv]
// ----------------------------------------------------------------------------
// half_open_connection_counter
// Table of IPv4 addresses with saturating counts of unanswered SYNs, plus
// indexed reads of table entries.
//
//   channel  dir  signals                       payload
//   req      in   req_valid / req_ready / req   req_t (opcode, flags, ips, index)
//   rsp      out  rsp_valid / rsp_ready / rsp   rsp_t (entry, count, status flags)
//
// A SYN or SYN-ACK scans the occupied entries until a match or the last one:
// the single table read port compares one stored address per cycle. A read
// sets the read address before commit; a packet with no lookup goes to commit.
// Reset clears the fill count and control; table contents are not cleared.
// The next item is accepted while a result waits in the output register; its
// own result then holds until that register is free.
// ----------------------------------------------------------------------------
`default_nettype none

module half_open_connection_counter
  import hocc_pkg::*;
#(
  parameter int ENTRIES    = 64,
  parameter int COUNT_BITS = 16
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic req_valid,
  output logic      req_ready,
  input  wire req_t req,
  output logic      rsp_valid,
  input  wire logic rsp_ready,
  output rsp_t      rsp
);

  ctl_cmd_t    cmd;
  ctl_status_t st;

  hocc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .st        (st),
    .cmd       (cmd)
  );

  hocc_dp #(
    .ENTRIES    (ENTRIES),
    .COUNT_BITS (COUNT_BITS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .cmd       (cmd),
    .st        (st),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

endmodule

`default_nettype wire
